// File: rtl/mbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbs_pkg - shared types and constants of the multichannel bilinear sampler
// Fixed field widths, register indexes, opcodes and the tag that travels
// with each pixel store read into the multiply-accumulate pipeline.
// ---------------------------------------------------------------------------
package mbs_pkg;

  localparam int COORD_BITS    = 19;
  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int CHAN_BITS     = 2;
  localparam int DIM_BITS      = 9;
  localparam int COUNT_BITS    = 3;
  localparam int CFG_IDX_BITS  = 2;

  // Bilinear weights reach exactly 1.0 in 2*F fraction bits
  localparam int WEIGHT_BITS   = 2 * FRACTION_BITS + 1;
  localparam int ACC_BITS      = SAMPLE_BITS + 2 * FRACTION_BITS;
  localparam int HALF_FIX      = 1 << (FRACTION_BITS - 1);
  localparam int NUM_TAPS      = 4;
  localparam int TAP_BITS      = 2;

  localparam logic [DIM_BITS-1:0]   RESET_WIDTH    = DIM_BITS'(256);
  localparam logic [DIM_BITS-1:0]   RESET_HEIGHT   = DIM_BITS'(256);
  localparam logic [COUNT_BITS-1:0] RESET_CHANNELS = COUNT_BITS'(4);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_BILINEAR = 2'd1,
    OP_NEAREST  = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_e;

  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic [TAP_BITS-1:0] tap;
  } mbs_tag_t;

endpackage
`default_nettype wire

// File: rtl/mbs_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbs_store - pixel sample memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module mbs_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             wr_en_i,
  input  wire logic [AW-1:0]                    wr_addr_i,
  input  wire logic [mbs_pkg::SAMPLE_BITS-1:0]  wr_data_i,
  input  wire logic                             rd_en_i,
  input  wire logic [AW-1:0]                    rd_addr_i,
  output      logic [mbs_pkg::SAMPLE_BITS-1:0]  rd_data_o
);

  logic [mbs_pkg::SAMPLE_BITS-1:0] mem [DEPTH];
  logic [mbs_pkg::SAMPLE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// File: rtl/mbs_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbs_mac - weighted accumulation of pixel store reads
// Holds the four neighbour weights of the current item, multiplies each read
// by the weight of its tap and sums the taps of one channel.
// ---------------------------------------------------------------------------
module mbs_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wgt_load_i,
  input  wire logic                                nearest_i,
  input  wire logic [mbs_pkg::FRACTION_BITS-1:0]   frac_x_i,
  input  wire logic [mbs_pkg::FRACTION_BITS-1:0]   frac_y_i,
  input  wire mbs_pkg::mbs_tag_t                   tag_i,
  input  wire logic [mbs_pkg::SAMPLE_BITS-1:0]     rd_data_i,
  output      logic                                done_o,
  output      logic [mbs_pkg::SAMPLE_BITS-1:0]     value_o
);

  localparam int WB = mbs_pkg::WEIGHT_BITS;
  localparam int AB = mbs_pkg::ACC_BITS;
  localparam int FB = mbs_pkg::FRACTION_BITS;

  logic [WB-1:0] fx, fy, gx, gy;
  logic [WB-1:0] weight_q [mbs_pkg::NUM_TAPS];

  mbs_pkg::mbs_tag_t tag_a_q, tag_b_q;
  logic [AB-1:0]     data_ext, wgt_ext;
  logic [AB-1:0]     prod_q;
  logic [AB-1:0]     acc_q;
  logic              done_q;

  assign fx = WB'(frac_x_i);
  assign fy = WB'(frac_y_i);
  assign gx = WB'(1 << FB) - fx;
  assign gy = WB'(1 << FB) - fy;

  // Nearest reads a single tap at unit weight
  always_ff @(posedge clk_i) begin
    if (wgt_load_i) begin
      if (nearest_i) begin
        weight_q[0] <= WB'(1 << (2 * FB));
      end else begin
        weight_q[0] <= gx * gy;
      end
      weight_q[1] <= fx * gy;
      weight_q[2] <= gx * fy;
      weight_q[3] <= fx * fy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      done_q  <= 1'b0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      done_q  <= tag_b_q.vld & tag_b_q.last;
    end
  end

  assign data_ext = AB'(rd_data_i);
  assign wgt_ext  = AB'(weight_q[tag_a_q.tap]);

  always_ff @(posedge clk_i) begin
    if (tag_a_q.vld) begin
      prod_q <= data_ext * wgt_ext;
    end
    if (tag_b_q.vld) begin
      if (tag_b_q.first) begin
        acc_q <= prod_q;
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = acc_q[2 * FB +: mbs_pkg::SAMPLE_BITS];

endmodule
`default_nettype wire

// File: rtl/multichannel_bilinear_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multichannel_bilinear_sampler - multichannel image store with sampling
// Pixel-interleaved sample memory with write, bilinear and nearest reads.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  opcode, coords, write data
//   out      source     out_valid_o / out_stall_i sample value, channel, flags
//   cfg      sink       cfg_valid_i / cfg_ready_o register index, data
//
// One item at a time. Sampling is paced by the single read port of the pixel
// store (one neighbour per cycle once a channel has started) and by the
// multiply-accumulate pipeline. A stall on the output holds the next channel
// until the result beat of the previous channel leaves. Reset clears control
// state only; the pixel store holds no reset value and needs no clearing pass.
// ---------------------------------------------------------------------------
module multichannel_bilinear_sampler #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output      logic                                  in_stall_o,
  input  wire logic [1:0]                            opcode_i,
  input  wire logic signed [mbs_pkg::COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [mbs_pkg::COORD_BITS-1:0] coord_y_i,
  input  wire logic [mbs_pkg::CHAN_BITS-1:0]         write_channel_i,
  input  wire logic [mbs_pkg::SAMPLE_BITS-1:0]       write_value_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_stall_i,
  output      logic [mbs_pkg::SAMPLE_BITS-1:0]       sample_value_o,
  output      logic [mbs_pkg::CHAN_BITS-1:0]         sample_channel_o,
  output      logic                                  status_o,
  output      logic                                  last_o,
  input  wire logic                                  cfg_valid_i,
  output      logic                                  cfg_ready_o,
  input  wire logic [mbs_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [mbs_pkg::DIM_BITS-1:0]          cfg_data_i
);

  localparam int CB    = mbs_pkg::COORD_BITS;
  localparam int FB    = mbs_pkg::FRACTION_BITS;
  localparam int IW    = CB - FB + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = $clog2(MAX_CHANNELS + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_ISSUE = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_ERR   = 3'd6;

  // Configuration registers
  logic [mbs_pkg::DIM_BITS-1:0]   width_q, height_q;
  logic [mbs_pkg::COUNT_BITS-1:0] chans_q;
  logic [WW-1:0]                  eff_w;
  logic [HW-1:0]                  eff_h;
  logic [NW-1:0]                  eff_c;

  // Sequencer
  logic [2:0]                     state_q, state_d;
  logic                           in_accept;
  mbs_pkg::opcode_e               op_q;
  logic signed [IW-1:0]           xi_q, yi_q;
  logic [FB-1:0]                  fx_q, fy_q;
  logic [mbs_pkg::CHAN_BITS-1:0]  wch_q;
  logic [mbs_pkg::SAMPLE_BITS-1:0] wval_q;
  logic signed [IW-1:0]           x_floor, y_floor, x_round, y_round;
  logic [CB:0]                    x_sum, y_sum;
  logic                           nearest_in;

  logic [PW-1:0]                  row_q;
  logic [AW-1:0]                  wc_q, base_q;
  logic [CW-1:0]                  ch_q, ch_d;
  logic [mbs_pkg::TAP_BITS-1:0]   tap_q, tap_d;
  logic                           item_ok;
  logic                           last_tap, last_ch;
  logic                           issue;
  logic [AW-1:0]                  tap_off, rd_addr;
  mbs_pkg::mbs_tag_t              tag;

  // Result beat register
  logic                           out_vld_q, out_vld_d;
  logic                           out_take;
  logic                           load_write, load_err, load_res;
  logic [mbs_pkg::SAMPLE_BITS-1:0] res_value_q;
  logic [mbs_pkg::CHAN_BITS-1:0]  res_chan_q;
  logic                           res_status_q, res_last_q;

  logic                           mac_done;
  logic [mbs_pkg::SAMPLE_BITS-1:0] mac_value;
  logic [mbs_pkg::SAMPLE_BITS-1:0] rd_data;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbs_pkg::RESET_WIDTH;
      height_q <= mbs_pkg::RESET_HEIGHT;
      chans_q  <= mbs_pkg::RESET_CHANNELS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbs_pkg::CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i;
        mbs_pkg::CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i;
        mbs_pkg::CFG_CHANNEL_COUNT: chans_q  <= cfg_data_i[mbs_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers to the built geometry; a channel count of zero counts as one
  assign eff_w = (int'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q);
  assign eff_h = (int'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_q);
  assign eff_c = (chans_q == '0) ? NW'(1) :
                 (int'(chans_q) > MAX_CHANNELS) ? NW'(MAX_CHANNELS) : NW'(chans_q);

  // ------------------------------------------------------- coordinate prep
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign nearest_in = (mbs_pkg::opcode_e'(opcode_i) == mbs_pkg::OP_NEAREST);

  assign x_floor = IW'(coord_x_i >>> FB);
  assign y_floor = IW'(coord_y_i >>> FB);

  // Round half away from zero: add one half, one less below zero, then floor
  assign x_sum = {coord_x_i[CB-1], coord_x_i} +
                 (coord_x_i[CB-1] ? (CB + 1)'(mbs_pkg::HALF_FIX - 1)
                                  : (CB + 1)'(mbs_pkg::HALF_FIX));
  assign y_sum = {coord_y_i[CB-1], coord_y_i} +
                 (coord_y_i[CB-1] ? (CB + 1)'(mbs_pkg::HALF_FIX - 1)
                                  : (CB + 1)'(mbs_pkg::HALF_FIX));
  assign x_round = IW'($signed(x_sum) >>> FB);
  assign y_round = IW'($signed(y_sum) >>> FB);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= mbs_pkg::opcode_e'(opcode_i);
      xi_q   <= nearest_in ? x_round : x_floor;
      yi_q   <= nearest_in ? y_round : y_floor;
      fx_q   <= coord_x_i[FB-1:0];
      fy_q   <= coord_y_i[FB-1:0];
      wch_q  <= write_channel_i;
      wval_q <= write_value_i;
    end
  end

  // ----------------------------------------------------------- range check
  always_comb begin
    int xv, yv, bump;
    logic xy_ok;
    xv    = int'(xi_q);
    yv    = int'(yi_q);
    bump  = (op_q == mbs_pkg::OP_BILINEAR) ? 1 : 0;
    xy_ok = (xv >= 0) && (yv >= 0) && (xv + bump < int'(eff_w)) &&
            (yv + bump < int'(eff_h));
    case (op_q)
      mbs_pkg::OP_WRITE:    item_ok = xy_ok && (int'(wch_q) < int'(eff_c));
      mbs_pkg::OP_BILINEAR: item_ok = xy_ok;
      mbs_pkg::OP_NEAREST:  item_ok = xy_ok;
      default:              item_ok = 1'b0;
    endcase
  end

  // ------------------------------------------------------ address compute
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      row_q <= PW'(yi_q[YW-1:0]) * PW'(eff_w);
      wc_q  <= AW'(eff_w) * AW'(eff_c);
    end
    if (state_q == ST_ADDR) begin
      base_q <= (AW'(row_q) + AW'(xi_q[XW-1:0])) * AW'(eff_c);
    end
  end

  always_comb begin
    case (tap_q)
      2'd0:    tap_off = '0;
      2'd1:    tap_off = AW'(eff_c);
      2'd2:    tap_off = wc_q;
      default: tap_off = wc_q + AW'(eff_c);
    endcase
  end

  assign rd_addr  = base_q + AW'(ch_q) + tap_off;
  assign last_tap = (op_q == mbs_pkg::OP_NEAREST) ||
                    (tap_q == mbs_pkg::TAP_BITS'(mbs_pkg::NUM_TAPS - 1));
  assign last_ch  = ((NW'(ch_q) + NW'(1)) == eff_c);

  // Start a channel only with the result register empty; nothing else
  // loads it until that channel's sum comes back.
  assign issue = (state_q == ST_ISSUE) && !((tap_q == '0) && out_vld_q);

  always_comb begin
    tag.vld   = issue;
    tag.first = (tap_q == '0);
    tag.last  = last_tap;
    tag.tap   = tap_q;
  end

  // --------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    tap_d   = tap_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = item_ok ? ST_ADDR : ST_ERR;
      end
      ST_ADDR: begin
        ch_d  = '0;
        tap_d = '0;
        state_d = (op_q == mbs_pkg::OP_WRITE) ? ST_WRITE : ST_ISSUE;
      end
      ST_WRITE: begin
        if (!out_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!out_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        if (issue) begin
          if (last_tap) begin
            tap_d   = '0;
            state_d = ST_DRAIN;
          end else begin
            tap_d = tap_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          if (last_ch) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      tap_q   <= tap_d;
    end
  end

  // ----------------------------------------------------------- result beat
  assign out_take   = out_vld_q & ~out_stall_i;
  assign load_write = (state_q == ST_WRITE) & ~out_vld_q;
  assign load_err   = (state_q == ST_ERR) & ~out_vld_q;
  assign load_res   = (state_q == ST_DRAIN) & mac_done;

  always_comb begin
    if (load_write || load_err || load_res) begin
      out_vld_d = 1'b1;
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_write) begin
      res_value_q  <= '0;
      res_chan_q   <= wch_q;
      res_status_q <= mbs_pkg::STATUS_OK;
      res_last_q   <= 1'b1;
    end else if (load_err) begin
      res_value_q  <= '0;
      res_chan_q   <= (op_q == mbs_pkg::OP_WRITE) ? wch_q : '0;
      res_status_q <= mbs_pkg::STATUS_ERR;
      res_last_q   <= 1'b1;
    end else if (load_res) begin
      res_value_q  <= mac_value;
      res_chan_q   <= mbs_pkg::CHAN_BITS'(ch_q);
      res_status_q <= mbs_pkg::STATUS_OK;
      res_last_q   <= last_ch;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign sample_value_o   = res_value_q;
  assign sample_channel_o = res_chan_q;
  assign status_o         = res_status_q;
  assign last_o           = res_last_q;

  // ------------------------------------------------------------ datapath
  mbs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_write),
    .wr_addr_i (base_q + AW'(wch_q)),
    .wr_data_i (wval_q),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mbs_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wgt_load_i (state_q == ST_CHECK),
    .nearest_i  (op_q == mbs_pkg::OP_NEAREST),
    .frac_x_i   (fx_q),
    .frac_y_i   (fy_q),
    .tag_i      (tag),
    .rd_data_i  (rd_data),
    .done_o     (mac_done),
    .value_o    (mac_value)
  );

endmodule
`default_nettype wire

// File: rtl/mbs_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbs_port_checker - port-level checks of the multichannel bilinear sampler
// Watches the input and result channels and the result flags over time.
// ---------------------------------------------------------------------------
module mbs_port_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [mbs_pkg::SAMPLE_BITS-1:0] sample_value_o,
  input wire logic [mbs_pkg::CHAN_BITS-1:0]   sample_channel_o,
  input wire logic                            status_o,
  input wire logic                            last_o
);

  // One item at a time: the beat after an accept is always stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous item in flight");

  // A rejected item gives a single zero-valued beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mbs_pkg::STATUS_ERR) |-> last_o && (sample_value_o == '0))
    else $error("error beat not final or not zero");

  // A result beat with last low carries OK status while the input stays stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (status_o == mbs_pkg::STATUS_OK) && in_stall_o)
    else $error("partial result beat with error status or open input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_value_o) && $stable(sample_channel_o)
                                   && $stable(status_o) && $stable(last_o))
    else $error("stalled result payload changed");

endmodule

bind multichannel_bilinear_sampler mbs_port_checker u_port_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .sample_value_o   (sample_value_o),
  .sample_channel_o (sample_channel_o),
  .status_o         (status_o),
  .last_o           (last_o)
);
`default_nettype wire

// File: test/multichannel_bilinear_sampler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multichannel_bilinear_sampler_test - self-checking bench for the sampler
// Walks a short table of writes, samples and rejections at the reset setup,
// then random traffic over a series of image shapes and channel counts.
// Rows with a typed status are scored by it, all else by an in-bench image
// model that every accepted item updates; result beats are compared field by
// field in order. Samples only touch entries written first.
module multichannel_bilinear_sampler_test;
  import mbs_pkg::*;

  localparam int STORE_DEPTH    = 256 * 256 * 4;
  localparam int RESET_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam int IDLE_GAP       = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    opcode_e                 op;
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic [CHAN_BITS-1:0]    wch;
    logic [SAMPLE_BITS-1:0]  wval;
  } stim_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [CHAN_BITS-1:0]   chan;
    logic                   status;
    logic                   last;
  } beat_t;

  typedef struct {
    stim_t s;
    bit    typed;
    logic  st;
  } row_t;

  typedef struct {
    logic [DIM_BITS-1:0] w_reg;
    logic [DIM_BITS-1:0] h_reg;
    logic [DIM_BITS-1:0] c_reg;
    bit                  steady;
    bit                  spare;
  } phase_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    opcode_i = OP_WRITE;
  logic signed [COORD_BITS-1:0]  coord_x_i = '0;
  logic signed [COORD_BITS-1:0]  coord_y_i = '0;
  logic [CHAN_BITS-1:0]          write_channel_i = '0;
  logic [SAMPLE_BITS-1:0]        write_value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [SAMPLE_BITS-1:0]        sample_value_o;
  logic [CHAN_BITS-1:0]          sample_channel_o;
  logic                          status_o;
  logic                          last_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i = '0;
  logic [DIM_BITS-1:0]           cfg_data_i = '0;

  multichannel_bilinear_sampler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .write_channel_i (write_channel_i),
    .write_value_i   (write_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_value_o  (sample_value_o),
    .sample_channel_o(sample_channel_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // image model state
  logic [SAMPLE_BITS-1:0] pixel_mem [STORE_DEPTH];
  bit                     pixel_set [STORE_DEPTH];
  logic [DIM_BITS-1:0]    width_reg  = RESET_WIDTH;
  logic [DIM_BITS-1:0]    height_reg = RESET_HEIGHT;
  logic [COUNT_BITS-1:0]  chans_reg  = RESET_CHANNELS;

  beat_t  fresh_beats[$];
  beat_t  expected_beats[$];
  beat_t  head_beat;
  row_t   directed[$];
  int     beats_in = 0;
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     steady = 1'b0;

  phase_t phases[9] = '{
    '{9'd3,   9'd2,   9'd4,   1'b0, 1'b0},
    '{9'd2,   9'd5,   9'd1,   1'b0, 1'b0},
    '{9'd256, 9'd256, 9'd4,   1'b1, 1'b0},
    '{9'd1,   9'd1,   9'd2,   1'b0, 1'b0},
    '{9'd0,   9'd4,   9'd3,   1'b0, 1'b0},
    '{9'h1FF, 9'd2,   9'd7,   1'b0, 1'b0},
    '{9'd5,   9'd3,   9'd0,   1'b0, 1'b1},
    '{9'd4,   9'd256, 9'd3,   1'b0, 1'b0},
    '{9'd7,   9'd1,   9'h0FD, 1'b0, 1'b0}
  };

  function automatic int eff_cols();
    return (width_reg > 9'd256) ? 256 : int'(width_reg);
  endfunction

  function automatic int eff_rows();
    return (height_reg > 9'd256) ? 256 : int'(height_reg);
  endfunction

  function automatic int eff_chans();
    if (chans_reg == '0) return 1;
    return (chans_reg > 3'd4) ? 4 : int'(chans_reg);
  endfunction

  function automatic int floor_fix(int v);
    return v >>> FRACTION_BITS;
  endfunction

  function automatic int round_fix(int v);
    if (v >= 0) return (v + HALF_FIX) >>> FRACTION_BITS;
    return -((-v + HALF_FIX) >>> FRACTION_BITS);
  endfunction

  function automatic bit on_image(int x, int y);
    return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
  endfunction

  function automatic int slot_of(int x, int y, int c);
    return ((y * eff_cols()) + x) * eff_chans() + c;
  endfunction

  function automatic logic [COORD_BITS-1:0] fix(int whole, int frac);
    return COORD_BITS'(whole * (1 << FRACTION_BITS) + frac);
  endfunction

  // Score one accepted item: update the image and queue its result beats.
  function automatic void predict_sample(stim_t s);
    int     n, vx, vy, x, y, c;
    longint fx, fy, gx, gy, p00, p01, p10, p11, acc;
    fresh_beats.delete();
    n  = eff_chans();
    vx = $signed(s.cx);
    vy = $signed(s.cy);
    case (s.op)
      OP_WRITE: begin
        x = floor_fix(vx);
        y = floor_fix(vy);
        if (on_image(x, y) && int'(s.wch) < n) begin
          pixel_mem[slot_of(x, y, s.wch)] = s.wval;
          pixel_set[slot_of(x, y, s.wch)] = 1'b1;
          fresh_beats.push_back('{'0, s.wch, STATUS_OK, 1'b1});
        end else begin
          fresh_beats.push_back('{'0, s.wch, STATUS_ERR, 1'b1});
        end
      end
      OP_BILINEAR: begin
        x  = floor_fix(vx);
        y  = floor_fix(vy);
        fx = vx & ((1 << FRACTION_BITS) - 1);
        fy = vy & ((1 << FRACTION_BITS) - 1);
        gx = (1 << FRACTION_BITS) - fx;
        gy = (1 << FRACTION_BITS) - fy;
        if (!(on_image(x, y) && on_image(x + 1, y + 1))) begin
          fresh_beats.push_back('{'0, '0, STATUS_ERR, 1'b1});
        end else begin
          for (c = 0; c < n; c++) begin
            p00 = pixel_mem[slot_of(x, y, c)];
            p01 = pixel_mem[slot_of(x + 1, y, c)];
            p10 = pixel_mem[slot_of(x, y + 1, c)];
            p11 = pixel_mem[slot_of(x + 1, y + 1, c)];
            acc = p00 * gx * gy + p01 * fx * gy + p10 * gx * fy + p11 * fx * fy;
            fresh_beats.push_back('{SAMPLE_BITS'(acc >> (2 * FRACTION_BITS)),
                                    CHAN_BITS'(c), STATUS_OK, c == n - 1});
          end
        end
      end
      OP_NEAREST: begin
        x = round_fix(vx);
        y = round_fix(vy);
        if (!on_image(x, y)) begin
          fresh_beats.push_back('{'0, '0, STATUS_ERR, 1'b1});
        end else begin
          for (c = 0; c < n; c++)
            fresh_beats.push_back('{pixel_mem[slot_of(x, y, c)], CHAN_BITS'(c),
                                    STATUS_OK, c == n - 1});
        end
      end
      default: fresh_beats.push_back('{'0, '0, STATUS_ERR, 1'b1});
    endcase
  endfunction

  function automatic void add_row(opcode_e op, logic [COORD_BITS-1:0] cx,
                                  logic [COORD_BITS-1:0] cy, int ch, int val,
                                  bit typed, logic st);
    row_t r;
    r.s     = '{op, cx, cy, CHAN_BITS'(ch), SAMPLE_BITS'(val)};
    r.typed = typed;
    r.st    = st;
    directed.push_back(r);
  endfunction

  // Offer one beat after a random gap, none in steady phases; score it once accepted.
  task automatic send_beat(input stim_t s, input bit typed, input logic st);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= s.op;
    coord_x_i       <= s.cx;
    coord_y_i       <= s.cy;
    write_channel_i <= s.wch;
    write_value_i   <= s.wval;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(s);
    if (typed)
      expected_beats.push_back('{'0, (s.op == OP_WRITE) ? s.wch : '0, st, 1'b1});
    else
      foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
    beats_in++;
  endtask

  // Hold the input and wait until every queued result has left.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input phase_t ph);
    logic [CFG_IDX_BITS-1:0] order[4];
    logic [DIM_BITS-1:0]     data;
    int                      k;
    order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CHANNEL_COUNT, CFG_UNUSED};
    for (k = 0; k < (ph.spare ? 4 : 3); k++) begin
      case (order[k])
        CFG_IMAGE_WIDTH:   data = ph.w_reg;
        CFG_IMAGE_HEIGHT:  data = ph.h_reg;
        CFG_CHANNEL_COUNT: data = ph.c_reg;
        default:           data = 9'h1FF;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (order[k])
        CFG_IMAGE_WIDTH:   width_reg = data;
        CFG_IMAGE_HEIGHT:  height_reg = data;
        CFG_CHANNEL_COUNT: chans_reg = data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_whole(int extent, int base);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(4))
        0:       return -1;
        1:       return 0;
        2:       return extent - 2;
        3:       return extent - 1;
        default: return extent;
      endcase
    end
    return base + int'($urandom_range(3));
  endfunction

  function automatic int pick_frac();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 25) return (1 << FRACTION_BITS) - 1;
    return $urandom_range((1 << FRACTION_BITS) - 1);
  endfunction

  function automatic stim_t random_item(int bx, int by);
    stim_t s;
    int    r;
    r      = $urandom_range(99);
    s.wch  = CHAN_BITS'($urandom_range(3));
    s.wval = SAMPLE_BITS'($urandom);
    if ($urandom_range(9) == 0) s.wval = $urandom_range(1) ? '1 : '0;
    s.cx = fix(pick_whole(eff_cols(), bx), pick_frac());
    s.cy = fix(pick_whole(eff_rows(), by), pick_frac());
    if (r < 25) begin
      s.op = OP_WRITE;
    end else if (r < 60) begin
      s.op = OP_BILINEAR;
    end else if (r < 90) begin
      s.op = OP_NEAREST;
    end else begin
      s.op = opcode_e'($urandom_range(3));
      s.cx = COORD_BITS'($urandom);
      s.cy = COORD_BITS'($urandom);
    end
    return s;
  endfunction

  // Write every entry a sample is about to read that holds no value yet.
  task automatic cover_reads(input stim_t s);
    int    vx, vy, x, y, k, c, taps;
    stim_t w;
    vx = $signed(s.cx);
    vy = $signed(s.cy);
    taps = 0;
    if (s.op == OP_BILINEAR) begin
      x = floor_fix(vx);
      y = floor_fix(vy);
      if (on_image(x, y) && on_image(x + 1, y + 1)) taps = 4;
    end else if (s.op == OP_NEAREST) begin
      x = round_fix(vx);
      y = round_fix(vy);
      if (on_image(x, y)) taps = 1;
    end
    for (k = 0; k < taps; k++) begin
      for (c = 0; c < eff_chans(); c++) begin
        if (!pixel_set[slot_of(x + (k & 1), y + (k >> 1), c)]) begin
          w = '{OP_WRITE, fix(x + (k & 1), pick_frac()), fix(y + (k >> 1), pick_frac()),
                CHAN_BITS'(c), SAMPLE_BITS'($urandom)};
          send_beat(w, 1'b0, STATUS_OK);
        end
      end
    end
  endtask

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 31);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: sample_value %0h sample_channel %0d status %0d",
               sample_value_o, sample_channel_o, status_o);
        errors++;
      end else begin
        head_beat = expected_beats.pop_front();
        if (sample_value_o !== head_beat.value) begin
          $error("sample_value: expected %0h, got %0h", head_beat.value, sample_value_o);
          errors++;
        end
        if (sample_channel_o !== head_beat.chan) begin
          $error("sample_channel: expected %0d, got %0d", head_beat.chan, sample_channel_o);
          errors++;
        end
        if (status_o !== head_beat.status) begin
          $error("status: expected %0d, got %0d", head_beat.status, status_o);
          errors++;
        end
        if (last_o !== head_beat.last) begin
          $error("last: expected %0d, got %0d", head_beat.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_t s;
    int    bx, by, target;
    // reset setup: 256 x 256, four channels
    add_row(OP_WRITE,    fix(0, 0),     fix(0, 0),     0, 'hFFFF, 1, STATUS_OK);
    add_row(OP_WRITE,    fix(0, 255),   fix(0, 17),    1, 0,      1, STATUS_OK);
    add_row(OP_WRITE,    fix(0, 0),     fix(0, 0),     2, 'h1234, 1, STATUS_OK);
    add_row(OP_WRITE,    fix(0, 0),     fix(0, 0),     3, 'h8000, 1, STATUS_OK);
    add_row(OP_NEAREST,  fix(0, 0),     fix(0, 0),     0, 0,      0, STATUS_OK);
    // just under half rounds toward the pixel, on both signs
    add_row(OP_NEAREST,  fix(0, 127),   fix(-1, 129),  0, 0,      0, STATUS_OK);
    add_row(OP_NEAREST,  fix(0, 0),     fix(-1, 128),  0, 0,      1, STATUS_ERR);
    add_row(OP_NEAREST,  fix(255, 128), fix(0, 0),     0, 0,      1, STATUS_ERR);
    add_row(OP_WRITE,    fix(256, 0),   fix(0, 0),     0, 'h5A5A, 1, STATUS_ERR);
    add_row(OP_WRITE,    fix(0, 0),     fix(-1, 255),  3, 'hA5A5, 1, STATUS_ERR);
    add_row(OP_WRITE,    19'h40000,     19'h3FFFF,     3, 'hFFFF, 1, STATUS_ERR);
    add_row(OP_WRITE,    19'h3FFFF,     19'h40000,     0, 0,      1, STATUS_ERR);
    add_row(OP_WRITE,    fix(255, 255), fix(255, 255), 3, 'hABCD, 1, STATUS_OK);
    add_row(OP_WRITE,    fix(255, 0),   fix(255, 0),   0, 'h0001, 1, STATUS_OK);
    add_row(OP_WRITE,    fix(255, 0),   fix(255, 0),   1, 'h7FFF, 1, STATUS_OK);
    add_row(OP_WRITE,    fix(255, 0),   fix(255, 0),   2, 'hFFFE, 1, STATUS_OK);
    add_row(OP_NEAREST,  fix(255, 127), fix(254, 200), 0, 0,      0, STATUS_OK);
    // bilinear needs the lower-right neighbour inside too
    add_row(OP_BILINEAR, fix(255, 0),   fix(0, 0),     0, 0,      1, STATUS_ERR);
    add_row(OP_BILINEAR, fix(-1, 255),  fix(0, 0),     0, 0,      1, STATUS_ERR);
    add_row(OP_BILINEAR, 19'h40000,     19'h40000,     0, 0,      1, STATUS_ERR);
    add_row(OP_BILINEAR, 19'h3FFFF,     19'h3FFFF,     0, 0,      1, STATUS_ERR);
    add_row(OP_RESERVED, 19'h3FFFF,     19'h40000,     3, 'hFFFF, 1, STATUS_ERR);
    add_row(OP_RESERVED, fix(0, 0),     fix(0, 0),     0, 0,      1, STATUS_ERR);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i].s, directed[i].typed, directed[i].st);

    foreach (phases[p]) begin
      settle();
      repeat (IDLE_GAP) @(posedge clk_i);
      program_regs(phases[p]);
      steady = phases[p].steady;
      bx = (eff_cols() > 4) ? $urandom_range(eff_cols() - 4) : 0;
      by = (eff_rows() > 4) ? $urandom_range(eff_rows() - 4) : 0;
      target = beats_in + PHASE_ITEMS;
      while (beats_in < target) begin
        s = random_item(bx, by);
        cover_reads(s);
        send_beat(s, 1'b0, STATUS_OK);
        if ($urandom_range(99) < 3) settle();
      end
    end

    settle();
    repeat (IDLE_GAP) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
